FILE: src/rnfd_pkg.sv
// Package for the nearest-value fill dilation block.
// Holds the stored cell type and the register, metric and mode codes.
// No dependencies.
package rnfd_pkg;

    typedef struct packed {
        logic        is_null;
        logic [31:0] value;
    } cell_t;

    localparam logic [2:0] REG_IMAGE_COLUMNS  = 3'd0;
    localparam logic [2:0] REG_WINDOW_HALF    = 3'd1;
    localparam logic [2:0] REG_DISTANCE_LIMIT = 3'd2;
    localparam logic [2:0] REG_METRIC_SELECT  = 3'd3;
    localparam logic [2:0] REG_ORIGINAL_MODE  = 3'd4;
    localparam logic [2:0] REG_ORIGINAL_FILL  = 3'd5;
    localparam logic [2:0] REG_GROW_MODE      = 3'd6;
    localparam logic [2:0] REG_GROW_FILL      = 3'd7;

    localparam logic [1:0] METRIC_CHEBYSHEV = 2'd1;
    localparam logic [1:0] METRIC_MANHATTAN = 2'd2;

    localparam logic [1:0] OMODE_KEEP = 2'd0;
    localparam logic [1:0] OMODE_FILL = 2'd1;

endpackage

FILE: src/rnfd_ram.sv
// Cell history memory: one write port and one registered read port.
// Depends on rnfd_pkg for the cell type.
module rnfd_ram #(
    parameter int DEPTH = 16393,
    parameter int AW    = 15
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  rnfd_pkg::cell_t   wr_data,
    input  logic [AW-1:0]     rd_addr,
    output rnfd_pkg::cell_t   rd_data
);

    rnfd_pkg::cell_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/rnfd_metric.sv
// Distance of a window offset under the selected metric.
// Depends on rnfd_pkg for the metric codes.
module rnfd_metric #(
    parameter int HW = 3,
    parameter int DW = 6
) (
    input  logic [HW-1:0] abs_dx,
    input  logic [HW-1:0] abs_dy,
    input  logic [1:0]    metric_select,
    output logic [DW-1:0] distance
);

    always_comb begin
        case (metric_select)
            rnfd_pkg::METRIC_CHEBYSHEV: begin
                distance = (abs_dx > abs_dy) ? DW'(abs_dx) : DW'(abs_dy);
            end
            rnfd_pkg::METRIC_MANHATTAN: begin
                distance = DW'(abs_dx) + DW'(abs_dy);
            end
            default: begin
                distance = DW'(abs_dx) * DW'(abs_dx) + DW'(abs_dy) * DW'(abs_dy);
            end
        endcase
    end

endmodule

FILE: src/raster_nearest_fill_dilation_top.sv
// Nearest-value fill dilation over a row-major raster cell stream.
// A cell during startup is only stored; otherwise a non-null centre passes CRD,
// CEV and DONE, and a null centre also scans its window, one history RAM read a cycle.
// The result register lets the next item enter while a result waits.
// After reset the history RAM is cleared to null, one entry a cycle, over all
// 2*MAX_HALF*MAX_COLUMNS + 2*MAX_HALF + 1 entries (16393 by default).
module raster_nearest_fill_dilation_top #(
    parameter int MAX_HALF    = 4,
    parameter int MAX_COLUMNS = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_cell_value,
    input  logic        s_cell_is_null,
    input  logic        s_is_padding,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value,
    output logic        m_result_is_null
);

    localparam int DEPTH = 2 * MAX_HALF * MAX_COLUMNS + 2 * MAX_HALF + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int HW    = $clog2(MAX_HALF + 1);
    localparam int IW    = $clog2(2 * MAX_HALF + 1);
    localparam int DW    = $clog2(2 * MAX_HALF * MAX_HALF + 1);
    localparam int KW    = (DW > 6) ? DW : 6;
    localparam int XW    = CW + IW + 1;
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_CRD  = 3'd2;
    localparam logic [2:0] ST_CEV  = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_LAST = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [11:0] image_columns_reg;
    logic [2:0]  window_half_reg;
    logic [5:0]  distance_limit_reg;
    logic [1:0]  metric_select_reg;
    logic [1:0]  original_mode_reg;
    logic [30:0] original_fill_reg;
    logic        grow_mode_reg;
    logic [31:0] grow_fill_reg;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] startup_reg, startup_next;
    logic [CW-1:0] centre_col_reg, centre_col_next;
    logic [AW-1:0] newest_reg, newest_next;
    logic [AW-1:0] delay_reg, delay_next;
    logic [CW-1:0] cols_reg, cols_next;
    logic [HW-1:0] half_reg, half_next;
    logic [AW-1:0] row_pos_reg, row_pos_next;
    logic [AW-1:0] cur_pos_reg, cur_pos_next;
    logic [IW-1:0] ix_reg, ix_next;
    logic [IW-1:0] iy_reg, iy_next;
    logic          cand_valid_reg, cand_valid_next;
    logic          cand_ok_reg, cand_ok_next;
    logic [DW-1:0] cand_dist_reg, cand_dist_next;
    logic          found_reg, found_next;
    logic [DW-1:0] best_dist_reg, best_dist_next;
    logic [31:0]   best_value_reg, best_value_next;
    logic          grow_path_reg, grow_path_next;
    logic [31:0]   res_value_reg, res_value_next;
    logic          res_null_reg, res_null_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_value_reg, m_value_next;
    logic          m_null_reg, m_null_next;

    logic [CW-1:0]   cols_eff;
    logic [HW-1:0]   half_eff;
    logic [AW-1:0]   delay_eff;
    logic [CW-1:0]   cc_eff;
    logic            accept;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    rnfd_pkg::cell_t ram_wdata;
    logic [AW-1:0]   ram_raddr;
    rnfd_pkg::cell_t ram_rdata;
    logic [HW-1:0]   abs_dx;
    logic [HW-1:0]   abs_dy;
    logic [DW-1:0]   distance;
    logic [XW-1:0]   col_sum;
    logic            in_bounds;
    logic [IW-1:0]   span;

    function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] p, input logic [AW-1:0] o);
        logic [AW:0] r;
        if (p >= o) begin
            r = {1'b0, p} - {1'b0, o};
        end else begin
            r = {1'b0, p} + DEPTH_C - {1'b0, o};
        end
        return r[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] p, input logic [AW-1:0] o);
        logic [AW:0] s;
        s = {1'b0, p} + {1'b0, o};
        if (s >= DEPTH_C) begin
            s = s - DEPTH_C;
        end
        return s[AW-1:0];
    endfunction

    rnfd_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    rnfd_metric #(.HW(HW), .DW(DW)) u_metric (
        .abs_dx        (abs_dx),
        .abs_dy        (abs_dy),
        .metric_select (metric_select_reg),
        .distance      (distance)
    );

    assign s_ready          = (state_reg == ST_IDLE);
    assign accept           = s_valid && s_ready;
    assign m_valid          = m_valid_reg;
    assign m_result_value   = m_value_reg;
    assign m_result_is_null = m_null_reg;

    always_comb begin
        if (image_columns_reg == 12'd0) begin
            cols_eff = CW'(1);
        end else if (32'(image_columns_reg) > MAX_COLUMNS) begin
            cols_eff = CW'(MAX_COLUMNS);
        end else begin
            cols_eff = CW'(image_columns_reg);
        end
        if (window_half_reg == 3'd0) begin
            half_eff = HW'(1);
        end else if (32'(window_half_reg) > MAX_HALF) begin
            half_eff = HW'(MAX_HALF);
        end else begin
            half_eff = HW'(window_half_reg);
        end
        delay_eff = AW'(half_eff) * AW'(cols_eff) + AW'(half_eff);
        cc_eff = (centre_col_reg >= cols_reg) ? '0 : centre_col_reg;
        span = IW'({half_reg, 1'b0});
    end

    always_comb begin
        abs_dx = (ix_reg >= IW'(half_reg)) ? HW'(ix_reg - IW'(half_reg))
                                            : HW'(IW'(half_reg) - ix_reg);
        abs_dy = (iy_reg >= IW'(half_reg)) ? HW'(iy_reg - IW'(half_reg))
                                            : HW'(IW'(half_reg) - iy_reg);
        col_sum = XW'(cc_eff) + XW'(ix_reg);
        in_bounds = (col_sum >= XW'(half_reg)) &&
                    ((col_sum - XW'(half_reg)) < XW'(cols_reg));
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = '{is_null: 1'b1, value: '0};
        ram_raddr = cur_pos_reg;
        if (state_reg == ST_CLR) begin
            ram_we = 1'b1;
        end else if (accept) begin
            ram_we    = 1'b1;
            ram_wdata = '{is_null: s_cell_is_null || s_is_padding, value: s_cell_value};
        end
        if (state_reg == ST_CRD) begin
            ram_raddr = sub_mod(newest_reg, delay_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        startup_next    = startup_reg;
        centre_col_next = centre_col_reg;
        newest_next     = newest_reg;
        delay_next      = delay_reg;
        cols_next       = cols_reg;
        half_next       = half_reg;
        row_pos_next    = row_pos_reg;
        cur_pos_next    = cur_pos_reg;
        ix_next         = ix_reg;
        iy_next         = iy_reg;
        cand_valid_next = cand_valid_reg;
        cand_ok_next    = cand_ok_reg;
        cand_dist_next  = cand_dist_reg;
        found_next      = found_reg;
        best_dist_next  = best_dist_reg;
        best_value_next = best_value_reg;
        grow_path_next  = grow_path_reg;
        res_value_next  = res_value_reg;
        res_null_next   = res_null_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_null_next     = m_null_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if ((state_reg == ST_SCAN || state_reg == ST_LAST) && cand_valid_reg &&
            cand_ok_reg && !ram_rdata.is_null &&
            (!found_reg || cand_dist_reg < best_dist_reg)) begin
            found_next      = 1'b1;
            best_dist_next  = cand_dist_reg;
            best_value_next = ram_rdata.value;
        end

        case (state_reg)
            ST_CLR: begin
                wp_next = wp_reg + AW'(1);
                if (32'(wp_reg) == DEPTH - 1) begin
                    wp_next    = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    wp_next         = (32'(wp_reg) == DEPTH - 1) ? '0 : wp_reg + AW'(1);
                    newest_next     = wp_reg;
                    cols_next       = cols_eff;
                    half_next       = half_eff;
                    delay_next      = delay_eff;
                    centre_col_next = (centre_col_reg >= cols_eff) ? '0 : centre_col_reg;
                    if (startup_reg < delay_eff) begin
                        startup_next = startup_reg + AW'(1);
                    end else begin
                        state_next = ST_CRD;
                    end
                end
            end
            ST_CRD: begin
                row_pos_next = sub_mod(newest_reg, AW'({delay_reg, 1'b0}));
                cur_pos_next = sub_mod(newest_reg, AW'({delay_reg, 1'b0}));
                state_next   = ST_CEV;
            end
            ST_CEV: begin
                ix_next         = '0;
                iy_next         = '0;
                cand_valid_next = 1'b0;
                found_next      = 1'b0;
                if (!ram_rdata.is_null) begin
                    grow_path_next = 1'b0;
                    case (original_mode_reg)
                        rnfd_pkg::OMODE_KEEP: begin
                            res_value_next = ram_rdata.value;
                            res_null_next  = 1'b0;
                        end
                        rnfd_pkg::OMODE_FILL: begin
                            res_value_next = {1'b0, original_fill_reg};
                            res_null_next  = 1'b0;
                        end
                        default: begin
                            res_value_next = '0;
                            res_null_next  = 1'b1;
                        end
                    endcase
                    state_next = ST_DONE;
                end else begin
                    grow_path_next = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cand_valid_next = 1'b1;
                cand_dist_next  = distance;
                cand_ok_next    = in_bounds && (distance != '0) &&
                                  (KW'(distance) <= KW'(distance_limit_reg));
                if (ix_reg == span) begin
                    ix_next      = '0;
                    iy_next      = iy_reg + IW'(1);
                    row_pos_next = add_mod(row_pos_reg, AW'(cols_reg));
                    cur_pos_next = add_mod(row_pos_reg, AW'(cols_reg));
                    if (iy_reg == span) begin
                        state_next = ST_LAST;
                    end
                end else begin
                    ix_next      = ix_reg + IW'(1);
                    cur_pos_next = add_mod(cur_pos_reg, AW'(1));
                end
            end
            ST_LAST: begin
                cand_valid_next = 1'b0;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (grow_path_reg) begin
                        m_null_next  = !found_reg;
                        m_value_next = !found_reg ? '0 :
                                       (grow_mode_reg ? grow_fill_reg : best_value_reg);
                    end else begin
                        m_null_next  = res_null_reg;
                        m_value_next = res_value_reg;
                    end
                    centre_col_next = (32'(cc_eff) + 1 >= 32'(cols_reg)) ? '0
                                                                       : cc_eff + CW'(1);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_columns_reg  <= 12'd2048;
            window_half_reg    <= 3'd1;
            distance_limit_reg <= 6'd1;
            metric_select_reg  <= '0;
            original_mode_reg  <= '0;
            original_fill_reg  <= '0;
            grow_mode_reg      <= 1'b0;
            grow_fill_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rnfd_pkg::REG_IMAGE_COLUMNS:  image_columns_reg  <= cfg_data[11:0];
                rnfd_pkg::REG_WINDOW_HALF:    window_half_reg    <= cfg_data[2:0];
                rnfd_pkg::REG_DISTANCE_LIMIT: distance_limit_reg <= cfg_data[5:0];
                rnfd_pkg::REG_METRIC_SELECT:  metric_select_reg  <= cfg_data[1:0];
                rnfd_pkg::REG_ORIGINAL_MODE:  original_mode_reg  <= cfg_data[1:0];
                rnfd_pkg::REG_ORIGINAL_FILL:  original_fill_reg  <= cfg_data[30:0];
                rnfd_pkg::REG_GROW_MODE:      grow_mode_reg      <= cfg_data[0];
                rnfd_pkg::REG_GROW_FILL:      grow_fill_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            wp_reg         <= '0;
            startup_reg    <= '0;
            centre_col_reg <= '0;
            cand_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            grow_path_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            startup_reg    <= startup_next;
            centre_col_reg <= centre_col_next;
            cand_valid_reg <= cand_valid_next;
            found_reg      <= found_next;
            grow_path_reg  <= grow_path_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        newest_reg     <= newest_next;
        delay_reg      <= delay_next;
        cols_reg       <= cols_next;
        half_reg       <= half_next;
        row_pos_reg    <= row_pos_next;
        cur_pos_reg    <= cur_pos_next;
        ix_reg         <= ix_next;
        iy_reg         <= iy_next;
        cand_ok_reg    <= cand_ok_next;
        cand_dist_reg  <= cand_dist_next;
        best_dist_reg  <= best_dist_next;
        best_value_reg <= best_value_next;
        res_value_reg  <= res_value_next;
        res_null_reg   <= res_null_next;
        m_value_reg    <= m_value_next;
        m_null_reg     <= m_null_next;
    end

endmodule
